/* src/upscl_pkg.sv */
// Shared types, widths and constants of the palette 2x upscaler.
package upscl_pkg;

   localparam int CH_W   = 8;
   localparam int RGB_W  = 3 * CH_W;
   localparam int IDX_W  = 8;
   localparam int POS_W  = 11;
   localparam int CFG_W  = 11;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam int MAX_WIDTH_DEFAULT    = 1024;
   localparam int PALETTE_SIZE_DEFAULT = 256;
   localparam int MAX_HEIGHT           = 1024;
   localparam int ROW_W                = $clog2(MAX_HEIGHT);

   localparam logic [CFG_W-1:0] SOURCE_WIDTH_RESET  = CFG_W'(320);
   localparam logic [CFG_W-1:0] SOURCE_HEIGHT_RESET = CFG_W'(240);

   localparam logic MODE_PALETTE = 1'b0;
   localparam logic MODE_PIXEL   = 1'b1;

   typedef enum logic [0:0] {
      REG_SOURCE_WIDTH,
      REG_SOURCE_HEIGHT
   } csr_reg_type;

   // output positions of the 3x3 window around (2x,2y), raster order
   localparam int SLOT_COUNT = 9;
   localparam int SLOT_W     = 4;

   typedef enum logic [SLOT_W-1:0] {
      SLOT_UL, SLOT_UC, SLOT_UR,
      SLOT_ML, SLOT_MC, SLOT_MR,
      SLOT_LL, SLOT_LC, SLOT_LR
   } slot_type;

endpackage

/* src/upscl_if.sv */
// Valid/ready channel interfaces for source items and output pixels.
interface upscl_req_if;
   import upscl_pkg::*;

   logic             valid;
   logic             ready;
   logic             mode;
   logic [IDX_W-1:0] color_index;
   logic [CH_W-1:0]  in_red;
   logic [CH_W-1:0]  in_green;
   logic [CH_W-1:0]  in_blue;

   modport source (output valid, mode, color_index, in_red, in_green, in_blue,
                   input ready);
   modport sink   (input valid, mode, color_index, in_red, in_green, in_blue,
                   output ready);
endinterface

interface upscl_rsp_if;
   import upscl_pkg::*;

   logic             valid;
   logic             ready;
   logic [POS_W-1:0] out_x;
   logic [POS_W-1:0] out_y;
   logic [CH_W-1:0]  out_red;
   logic [CH_W-1:0]  out_green;
   logic [CH_W-1:0]  out_blue;
   logic             last_of_run;

   modport source (output valid, out_x, out_y, out_red, out_green, out_blue, last_of_run,
                   input ready);
   modport sink   (input valid, out_x, out_y, out_red, out_green, out_blue, last_of_run,
                   output ready);
endinterface

/* src/palette_image_2x_interpolating_upscaler.sv */
// Palette-indexed 2x interpolating upscaler: palette, row store and emission sequencer.
//
// Usage:
//  req carries palette writes (mode 0: color_index and RGB) and source pixels
//  (mode 1: color_index only) in raster order. rsp carries the doubled image's
//  pixels with their (out_x, out_y) position; last_of_run marks the final
//  output pixel belonging to one source pixel. A palette write gives no output.
//  Each pixel gives 1 to 9 output pixels, usually 4 (more at the right and
//  bottom edges, where the last column and row are replicated).
//  A pixel's first output passes the palette/row-store read, the window load
//  and the output register, in that order.
//  Throughput: one output pixel per cycle from the output register while rsp
//  is ready; the next pixel's memory reads overlap with the current pixel's
//  outputs.
//  The APB port sets source_width (0x0) and source_height (0x4); write it
//  only when the block is idle. pready is tied high.
//  Reset clears the frame counters, the neighbor registers and all valid
//  flags; palette and row store keep their contents and must be written
//  before use. When rsp stalls, the output register holds its item and the
//  pipeline backs up until req.ready drops.
module palette_image_2x_interpolating_upscaler #(
   parameter int MAX_WIDTH    = upscl_pkg::MAX_WIDTH_DEFAULT,
   parameter int PALETTE_SIZE = upscl_pkg::PALETTE_SIZE_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   upscl_req_if.sink                     req,
   upscl_rsp_if.source                   rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [upscl_pkg::CSR_AW-1:0]  paddr,
   input  logic [upscl_pkg::CSR_DW-1:0]  pwdata,
   output logic [upscl_pkg::CSR_DW-1:0]  prdata,
   output logic                          pready
);
   import upscl_pkg::*;

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int PAW  = $clog2(PALETTE_SIZE);
   localparam int WCMP = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

   // ---------------- configuration ----------------
   logic [CFG_W-1:0] src_width_ff, src_height_ff;
   logic             csr_wr;
   csr_reg_type      csr_sel;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_sel = csr_reg_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SOURCE_WIDTH_RESET;
         src_height_ff <= SOURCE_HEIGHT_RESET;
      end else if (csr_wr) begin
         unique case (csr_sel)
            REG_SOURCE_WIDTH:  src_width_ff  <= pwdata[CFG_W-1:0];
            REG_SOURCE_HEIGHT: src_height_ff <= pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_SOURCE_WIDTH:  prdata = CSR_DW'(src_width_ff);
         REG_SOURCE_HEIGHT: prdata = CSR_DW'(src_height_ff);
         default:           prdata = '0;
      endcase
   end

   // clamped geometry
   logic [WCMP-1:0]  w_eff;
   logic [CFG_W-1:0] h_eff;

   always_comb begin
      if (src_width_ff == '0)
         w_eff = WCMP'(1);
      else if (WCMP'(src_width_ff) > WCMP'(MAX_WIDTH))
         w_eff = WCMP'(MAX_WIDTH);
      else
         w_eff = WCMP'(src_width_ff);

      if (src_height_ff == '0)
         h_eff = CFG_W'(1);
      else if (src_height_ff > CFG_W'(MAX_HEIGHT))
         h_eff = CFG_W'(MAX_HEIGHT);
      else
         h_eff = src_height_ff;
   end

   // ---------------- handshake and stage control ----------------
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic s1_move, emit, emit_last, accept, pix_accept, pal_write;

   assign emit       = s2_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign s1_move    = s1_valid_ff && (!s2_valid_ff || (emit && emit_last));
   assign req.ready  = !s1_valid_ff || s1_move;
   assign accept     = req.valid && req.ready;
   assign pix_accept = accept && (req.mode == MODE_PIXEL);

   logic idx_in_range;
   assign idx_in_range = ({1'b0, req.color_index} < 9'(PALETTE_SIZE));
   assign pal_write    = accept && (req.mode == MODE_PALETTE) && idx_in_range;

   // ---------------- frame counters ----------------
   logic [CW-1:0]    col_ff;
   logic [ROW_W-1:0] row_ff;
   logic             last_col, last_row;

   assign last_col = (WCMP'(col_ff) + WCMP'(1)) >= w_eff;
   assign last_row = (CFG_W'(row_ff) + CFG_W'(1)) >= h_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (pix_accept) begin
         if (last_col) begin
            col_ff <= '0;
            row_ff <= last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_ff <= col_ff + CW'(1);
         end
      end
   end

   // ---------------- memories ----------------
   logic [RGB_W-1:0] palette_mem [PALETTE_SIZE];
   logic [RGB_W-1:0] row_mem [MAX_WIDTH];
   logic [RGB_W-1:0] pal_rdata_ff, row_rdata_ff;
   logic [PAW-1:0]   pal_addr;
   logic [CW-1:0]    s1_col_ff;
   logic [RGB_W-1:0] cur, up;

   assign pal_addr = req.color_index[PAW-1:0];

   always_ff @(posedge clock) begin
      if (pal_write)
         palette_mem[pal_addr] <= {req.in_red, req.in_green, req.in_blue};
      if (pix_accept)
         pal_rdata_ff <= palette_mem[pal_addr];
   end

   always_ff @(posedge clock) begin
      if (s1_move)
         row_mem[s1_col_ff] <= cur;
      if (pix_accept)
         row_rdata_ff <= row_mem[col_ff];
   end

   // ---------------- stage 1: lookup results ----------------
   logic [ROW_W-1:0] s1_row_ff;
   logic             s1_in_range_ff, s1_fwd_ff;
   logic             s1_has_left_ff, s1_has_up_ff, s1_last_col_ff, s1_last_row_ff;
   logic [RGB_W-1:0] left_ff, ul_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (pix_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_accept) begin
         s1_col_ff      <= col_ff;
         s1_row_ff      <= row_ff;
         s1_in_range_ff <= idx_in_range;
         // row store entry written at this same edge by the item ahead
         s1_fwd_ff      <= s1_move && (s1_col_ff == col_ff);
         s1_has_left_ff <= (col_ff != '0);
         s1_has_up_ff   <= (row_ff != '0);
         s1_last_col_ff <= last_col;
         s1_last_row_ff <= last_row;
      end
   end

   assign cur = s1_in_range_ff ? pal_rdata_ff : '0;
   assign up  = s1_fwd_ff ? left_ff : row_rdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         ul_ff   <= '0;
      end else if (s1_move) begin
         left_ff <= cur;
         ul_ff   <= up;
      end
   end

   // ---------------- stage 2: window emission ----------------
   logic [RGB_W-1:0]      s2_cur_ff, s2_up_ff, s2_lf_ff, s2_ul_ff;
   logic [POS_W-1:0]      s2_x_ff, s2_y_ff;
   logic [SLOT_COUNT-1:0] s2_mask_ff, mask_in, mask_left;
   slot_type              sel;

   always_comb begin
      mask_in[SLOT_UL] = s1_has_up_ff && s1_has_left_ff;
      mask_in[SLOT_UC] = s1_has_up_ff;
      mask_in[SLOT_UR] = s1_has_up_ff && s1_last_col_ff;
      mask_in[SLOT_ML] = s1_has_left_ff;
      mask_in[SLOT_MC] = 1'b1;
      mask_in[SLOT_MR] = s1_last_col_ff;
      mask_in[SLOT_LL] = s1_last_row_ff && s1_has_left_ff;
      mask_in[SLOT_LC] = s1_last_row_ff;
      mask_in[SLOT_LR] = s1_last_row_ff && s1_last_col_ff;
   end

   // lowest pending position goes first
   always_comb begin
      sel = SLOT_MC;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (s2_mask_ff[i])
            sel = slot_type'(SLOT_W'(i));
      end
   end

   always_comb begin
      mask_left      = s2_mask_ff;
      mask_left[sel] = 1'b0;
   end

   assign emit_last = (mask_left == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_move) begin
         s2_valid_ff <= 1'b1;
      end else if (emit && emit_last) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_cur_ff  <= cur;
         s2_up_ff   <= up;
         s2_lf_ff   <= left_ff;
         s2_ul_ff   <= ul_ff;
         s2_x_ff    <= POS_W'({s1_col_ff, 1'b0});
         s2_y_ff    <= POS_W'({s1_row_ff, 1'b0});
         s2_mask_ff <= mask_in;
      end else if (emit) begin
         s2_mask_ff <= mask_left;
      end
   end

   // per-channel truncating means
   function automatic logic [RGB_W-1:0] mean2(input logic [RGB_W-1:0] a,
                                              input logic [RGB_W-1:0] b);
      logic [RGB_W-1:0] res;
      logic [CH_W:0]    sum;
      res = '0;
      for (int c = 0; c < 3; c++) begin
         sum = {1'b0, a[c*CH_W +: CH_W]} + {1'b0, b[c*CH_W +: CH_W]};
         res[c*CH_W +: CH_W] = sum[CH_W:1];
      end
      return res;
   endfunction

   function automatic logic [RGB_W-1:0] mean4(input logic [RGB_W-1:0] a,
                                              input logic [RGB_W-1:0] b,
                                              input logic [RGB_W-1:0] c,
                                              input logic [RGB_W-1:0] d);
      logic [RGB_W-1:0] res;
      logic [CH_W+1:0]  sum;
      res = '0;
      for (int k = 0; k < 3; k++) begin
         sum = {2'b00, a[k*CH_W +: CH_W]} + {2'b00, b[k*CH_W +: CH_W]}
             + {2'b00, c[k*CH_W +: CH_W]} + {2'b00, d[k*CH_W +: CH_W]};
         res[k*CH_W +: CH_W] = sum[CH_W+1:2];
      end
      return res;
   endfunction

   logic [RGB_W-1:0] vmean, hmean, qmean, pix_rgb;
   logic [POS_W-1:0] pix_x, pix_y;

   assign vmean = mean2(s2_up_ff, s2_cur_ff);
   assign hmean = mean2(s2_lf_ff, s2_cur_ff);
   assign qmean = mean4(s2_ul_ff, s2_up_ff, s2_lf_ff, s2_cur_ff);

   always_comb begin
      unique case (sel)
         SLOT_UL: pix_rgb = qmean;
         SLOT_UC, SLOT_UR: pix_rgb = vmean;
         SLOT_ML, SLOT_LL: pix_rgb = hmean;
         default: pix_rgb = s2_cur_ff;
      endcase

      unique case (sel)
         SLOT_UL, SLOT_ML, SLOT_LL: pix_x = s2_x_ff - POS_W'(1);
         SLOT_UR, SLOT_MR, SLOT_LR: pix_x = s2_x_ff + POS_W'(1);
         default:                   pix_x = s2_x_ff;
      endcase

      unique case (sel)
         SLOT_UL, SLOT_UC, SLOT_UR: pix_y = s2_y_ff - POS_W'(1);
         SLOT_LL, SLOT_LC, SLOT_LR: pix_y = s2_y_ff + POS_W'(1);
         default:                   pix_y = s2_y_ff;
      endcase
   end

   // ---------------- output register ----------------
   logic [POS_W-1:0] rsp_x_ff, rsp_y_ff;
   logic [RGB_W-1:0] rsp_rgb_ff;
   logic             rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_x_ff    <= pix_x;
         rsp_y_ff    <= pix_y;
         rsp_rgb_ff  <= pix_rgb;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_x       = rsp_x_ff;
   assign rsp.out_y       = rsp_y_ff;
   assign rsp.out_red     = rsp_rgb_ff[2*CH_W +: CH_W];
   assign rsp.out_green   = rsp_rgb_ff[CH_W +: CH_W];
   assign rsp.out_blue    = rsp_rgb_ff[0 +: CH_W];
   assign rsp.last_of_run = rsp_last_ff;

endmodule

/* src/upscl_checker.sv */
// Port-level checks on the upscaler's output stream, bound to the top level.
module upscl_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [upscl_pkg::POS_W-1:0]  out_x,
   input logic [upscl_pkg::POS_W-1:0]  out_y,
   input logic [upscl_pkg::CH_W-1:0]   out_red,
   input logic [upscl_pkg::CH_W-1:0]   out_green,
   input logic [upscl_pkg::CH_W-1:0]   out_blue,
   input logic                         last_of_run
);
   import upscl_pkg::*;

   logic             rsp_fire;
   logic [3:0]       run_count_ff, run_count_in;
   logic [POS_W-1:0] prev_x_ff, prev_y_ff;
   logic             prev_last_ff;

   assign rsp_fire     = rsp_valid && rsp_ready;
   assign run_count_in = last_of_run ? 4'd0 : run_count_ff + 4'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_count_ff <= 4'd0;
         prev_last_ff <= 1'b1;
      end else if (rsp_fire) begin
         run_count_ff <= run_count_in;
         prev_last_ff <= last_of_run;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire) begin
         prev_x_ff <= out_x;
         prev_y_ff <= out_y;
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_x) && $stable(out_y)
         && $stable(out_red) && $stable(out_green) && $stable(out_blue)
         && $stable(last_of_run))
      else $error("output item changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("output valid right after reset");

   // one source pixel covers at most a 3x3 window
   a_run_length: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> (run_count_ff < 4'd8) || last_of_run)
      else $error("more than nine outputs for one pixel");

   // within a run, outputs walk the window in raster order
   a_run_order: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !prev_last_ff |->
         (out_y == prev_y_ff && out_x == POS_W'(prev_x_ff + POS_W'(1)))
         || (out_y == POS_W'(prev_y_ff + POS_W'(1))))
      else $error("outputs of one pixel out of raster order");

endmodule

bind palette_image_2x_interpolating_upscaler upscl_checker u_upscl_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .out_x       (rsp.out_x),
   .out_y       (rsp.out_y),
   .out_red     (rsp.out_red),
   .out_green   (rsp.out_green),
   .out_blue    (rsp.out_blue),
   .last_of_run (rsp.last_of_run)
);

/* tb/palette_image_2x_interpolating_upscaler_tb.sv */
// Self-checking testbench of the palette 2x upscaler: paced driver, stalling sink, predictor.
`timescale 1ns / 1ps

module palette_image_2x_interpolating_upscaler_tb;
   import upscl_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int LONG_HOLD    = 300;
   localparam int RANDOM_ITEMS = 330;

   typedef struct packed {
      logic             mode;
      logic [IDX_W-1:0] color_index;
      logic [CH_W-1:0]  in_red;
      logic [CH_W-1:0]  in_green;
      logic [CH_W-1:0]  in_blue;
   } src_item_type;

   typedef struct packed {
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic [CH_W-1:0]  red;
      logic [CH_W-1:0]  green;
      logic [CH_W-1:0]  blue;
      logic             last_of_run;
   } out_pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   upscl_req_if req_bus ();
   upscl_rsp_if rsp_bus ();

   logic              drv_valid = 1'b0;
   src_item_type      drv_item  = '0;
   logic              rcv_ready = 1'b0;
   logic              psel      = 1'b0;
   logic              penable   = 1'b0;
   logic              pwrite    = 1'b0;
   logic [CSR_AW-1:0] paddr     = '0;
   logic [CSR_DW-1:0] pwdata    = '0;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   assign req_bus.valid       = drv_valid;
   assign req_bus.mode        = drv_item.mode;
   assign req_bus.color_index = drv_item.color_index;
   assign req_bus.in_red      = drv_item.in_red;
   assign req_bus.in_green    = drv_item.in_green;
   assign req_bus.in_blue     = drv_item.in_blue;
   assign rsp_bus.ready       = rcv_ready;

   palette_image_2x_interpolating_upscaler uut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [RGB_W-1:0] palette_mem [PALETTE_SIZE_DEFAULT];
   logic [RGB_W-1:0] row_mem [MAX_WIDTH_DEFAULT];
   logic [RGB_W-1:0] left_px = '0;
   logic [RGB_W-1:0] upper_left_px = '0;
   int unsigned      col_cnt = 0;
   int unsigned      row_cnt = 0;
   logic [CFG_W-1:0] cfg_width  = SOURCE_WIDTH_RESET;
   logic [CFG_W-1:0] cfg_height = SOURCE_HEIGHT_RESET;

   src_item_type  pending_items [$];
   out_pixel_type expected_pixels [$];
   out_pixel_type want;

   // stimulus bookkeeping
   logic [IDX_W-1:0] known_colors [$];
   bit               color_known [PALETTE_SIZE_DEFAULT];
   int items_queued   = 0;
   int pixels_queued  = 0;
   int palette_queued = 0;
   int geometry_count = 0;
   int nine_runs      = 0;
   int pixels_checked = 0;
   int mismatches     = 0;
   int cycle_count    = 0;

   int burst_left = 1;
   int gap_left   = 0;
   int holds_requested = 0;
   int holds_served    = 0;
   int hold_left   = 0;
   int stall_style = 0;
   int style_left  = 0;
   int pattern_phase = 0;

   function automatic int unsigned dimension_of(logic [CFG_W-1:0] v, int unsigned limit);
      if (v == 0)
         return 1;
      if (v > limit)
         return limit;
      return 32'(v);
   endfunction

   function automatic logic [RGB_W-1:0] avg2(logic [RGB_W-1:0] a, logic [RGB_W-1:0] b);
      logic [RGB_W-1:0] res;
      logic [CH_W:0]    sum;
      for (int s = 0; s < RGB_W; s += CH_W) begin
         sum = {1'b0, a[s +: CH_W]} + {1'b0, b[s +: CH_W]};
         res[s +: CH_W] = sum[CH_W:1];
      end
      return res;
   endfunction

   function automatic logic [RGB_W-1:0] avg4(logic [RGB_W-1:0] a, logic [RGB_W-1:0] b,
                                             logic [RGB_W-1:0] c, logic [RGB_W-1:0] d);
      logic [RGB_W-1:0] res;
      logic [CH_W+1:0]  sum;
      for (int s = 0; s < RGB_W; s += CH_W) begin
         sum = {2'b00, a[s +: CH_W]} + {2'b00, b[s +: CH_W]}
             + {2'b00, c[s +: CH_W]} + {2'b00, d[s +: CH_W]};
         res[s +: CH_W] = sum[CH_W+1:2];
      end
      return res;
   endfunction

   function automatic out_pixel_type out_px(int unsigned x, int unsigned y,
                                            logic [RGB_W-1:0] c);
      out_pixel_type p;
      p.x = POS_W'(x);
      p.y = POS_W'(y);
      {p.red, p.green, p.blue} = c;
      p.last_of_run = 1'b0;
      return p;
   endfunction

   task automatic predict_upscale(input src_item_type it);
      logic [RGB_W-1:0] cur, up, hm, vm;
      int unsigned      w, h, col, row, slot;
      logic             has_left, has_up, last_col, last_row;
      out_pixel_type    run [$];
      if (it.mode == MODE_PALETTE) begin
         palette_mem[it.color_index] = {it.in_red, it.in_green, it.in_blue};
         return;
      end
      w = dimension_of(cfg_width, MAX_WIDTH_DEFAULT);
      h = dimension_of(cfg_height, MAX_HEIGHT);
      col = col_cnt;
      row = row_cnt;
      slot = (col < MAX_WIDTH_DEFAULT) ? col : MAX_WIDTH_DEFAULT - 1;
      cur = palette_mem[it.color_index];
      up = row_mem[slot];
      has_left = col > 0;
      has_up = row > 0;
      last_col = col + 1 >= w;
      last_row = row + 1 >= h;
      vm = avg2(up, cur);
      hm = has_left ? avg2(left_px, cur) : cur;
      // 3x3 window around (2x,2y) in raster order
      if (has_up) begin
         if (has_left)
            run.push_back(out_px(2*col - 1, 2*row - 1, avg4(upper_left_px, up, left_px, cur)));
         run.push_back(out_px(2*col, 2*row - 1, vm));
         if (last_col)
            run.push_back(out_px(2*col + 1, 2*row - 1, vm));
      end
      if (has_left)
         run.push_back(out_px(2*col - 1, 2*row, hm));
      run.push_back(out_px(2*col, 2*row, cur));
      if (last_col)
         run.push_back(out_px(2*col + 1, 2*row, cur));
      if (last_row) begin
         if (has_left)
            run.push_back(out_px(2*col - 1, 2*row + 1, hm));
         run.push_back(out_px(2*col, 2*row + 1, cur));
         if (last_col)
            run.push_back(out_px(2*col + 1, 2*row + 1, cur));
      end
      run[run.size() - 1].last_of_run = 1'b1;
      if (run.size() == SLOT_COUNT)
         nine_runs++;
      foreach (run[i])
         expected_pixels.push_back(run[i]);
      upper_left_px = up;
      row_mem[slot] = cur;
      left_px = cur;
      if (last_col) begin
         col_cnt = 0;
         row_cnt = last_row ? 0 : row + 1;
      end else begin
         col_cnt = col + 1;
      end
   endtask

   task automatic check_field(string field, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch at (%0d,%0d): expected %0d, actual %0d",
                  $time, field, want.x, want.y, exp_val, act_val);
         mismatches++;
      end
   endtask

   // source driver: bursts of items separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else begin
         if (drv_valid && req_bus.ready) begin
            predict_upscale(drv_item);
            void'(pending_items.pop_front());
         end
         if (!drv_valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               drv_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               drv_item <= pending_items[0];
               drv_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               drv_valid <= 1'b0;
            end
         end
      end
   end

   // result sink: changing stall styles plus an occasional long hold
   always @(posedge clock) begin
      if (reset) begin
         rcv_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rcv_ready <= 1'b0;
      end else if (holds_served != holds_requested) begin
         holds_served++;
         hold_left = LONG_HOLD;
         rcv_ready <= 1'b0;
      end else begin
         if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left = $urandom_range(20, 120);
         end else begin
            style_left--;
         end
         pattern_phase++;
         case (stall_style)
            0: rcv_ready <= 1'b1;
            1: rcv_ready <= ($urandom_range(0, 9) < 7);
            2: rcv_ready <= (pattern_phase % 4 != 0);
            default: rcv_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rcv_ready) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected output pixel at (%0d,%0d): expected none, actual rgb %h%h%h",
                     $time, rsp_bus.out_x, rsp_bus.out_y,
                     rsp_bus.out_red, rsp_bus.out_green, rsp_bus.out_blue);
            mismatches++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("out_x", 32'(want.x), 32'(rsp_bus.out_x));
            check_field("out_y", 32'(want.y), 32'(rsp_bus.out_y));
            check_field("out_red", 32'(want.red), 32'(rsp_bus.out_red));
            check_field("out_green", 32'(want.green), 32'(rsp_bus.out_green));
            check_field("out_blue", 32'(want.blue), 32'(rsp_bus.out_blue));
            check_field("last_of_run", 32'(want.last_of_run), 32'(rsp_bus.last_of_run));
            pixels_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d output pixels still outstanding",
                  cycle_count, expected_pixels.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic queue_palette(logic [IDX_W-1:0] idx, logic [RGB_W-1:0] rgb);
      src_item_type it;
      it.mode = MODE_PALETTE;
      it.color_index = idx;
      {it.in_red, it.in_green, it.in_blue} = rgb;
      pending_items.push_back(it);
      if (!color_known[idx]) begin
         color_known[idx] = 1'b1;
         known_colors.push_back(idx);
      end
      items_queued++;
      palette_queued++;
   endtask

   task automatic queue_pixel(logic [IDX_W-1:0] idx);
      src_item_type it;
      it.mode = MODE_PIXEL;
      it.color_index = idx;
      // color fields are don't-care for pixels
      it.in_red = CH_W'($urandom);
      it.in_green = CH_W'($urandom);
      it.in_blue = CH_W'($urandom);
      pending_items.push_back(it);
      items_queued++;
      pixels_queued++;
   endtask

   // pixels with random written colors, palette updates mixed in at pal_pct percent
   task automatic send_pixels(int n, int pal_pct);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < pal_pct)
            queue_palette(IDX_W'($urandom), RGB_W'($urandom));
         queue_pixel(known_colors[$urandom_range(0, known_colors.size() - 1)]);
      end
   endtask

   task automatic wait_drained();
      while (pending_items.size() > 0 || drv_valid || expected_pixels.size() > 0)
         @(posedge clock);
      // a trailing palette write may still be in flight
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(csr_reg_type which, logic [CFG_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_AW'(4 * int'(which));
      pwdata <= CSR_DW'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (which == REG_SOURCE_WIDTH)
         cfg_width = value;
      else
         cfg_height = value;
   endtask

   // Widening below the first row would read row-store columns never written,
   // so the width is kept in that case.
   task automatic set_geometry(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
      wait_drained();
      if (row_cnt != 0 && dimension_of(w, MAX_WIDTH_DEFAULT) >
                          dimension_of(cfg_width, MAX_WIDTH_DEFAULT))
         w = cfg_width;
      csr_write(REG_SOURCE_WIDTH, w);
      csr_write(REG_SOURCE_HEIGHT, h);
      geometry_count++;
   endtask

   function automatic int unsigned pixels_to_frame_end();
      int unsigned w, h, n;
      w = dimension_of(cfg_width, MAX_WIDTH_DEFAULT);
      h = dimension_of(cfg_height, MAX_HEIGHT);
      if (col_cnt == 0 && row_cnt == 0)
         return 0;
      n = (col_cnt >= w) ? 1 : w - col_cnt;
      if (row_cnt + 1 < h)
         n += (h - row_cnt - 1) * w;
      return n;
   endfunction

   initial begin
      int directed_items;
      int scenario;
      int unsigned w, h, n;
      bit first_pass;

      for (int i = 0; i < PALETTE_SIZE_DEFAULT; i++)
         palette_mem[i] = '0;
      for (int i = 0; i < MAX_WIDTH_DEFAULT; i++)
         row_mem[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: color extremes, reset geometry, zero sizes, full 2x2 frames
      queue_palette(8'h00, 24'h000000);
      queue_palette(8'hFF, 24'hFFFFFF);
      queue_palette(8'h5A, 24'h01FE80);
      queue_palette(8'hA5, 24'hFE017F);
      queue_pixel(8'hFF);
      queue_pixel(8'h00);
      queue_pixel(8'h5A);
      // zero size reads as one: column 3 now closes both the row and the frame
      set_geometry(11'd0, 11'd0);
      queue_pixel(8'hA5);
      queue_pixel(8'h00);
      set_geometry(11'd2, 11'd2);
      queue_pixel(8'hFF);
      queue_pixel(8'h00);
      queue_pixel(8'h00);
      queue_pixel(8'hFF);
      queue_pixel(8'hA5);
      queue_palette(8'h5A, 24'h7F8001);
      queue_pixel(8'h5A);
      queue_pixel(8'hFF);
      queue_pixel(8'h00);
      directed_items = items_queued;

      for (int i = 0; i < 6; i++)
         queue_palette(IDX_W'($urandom), RGB_W'($urandom));

      first_pass = 1'b1;
      while (items_queued - directed_items < RANDOM_ITEMS) begin
         scenario = first_pass ? 9 : $urandom_range(0, 11);
         first_pass = 1'b0;
         case (scenario)
            7: begin
               // very wide rows, cut short by narrowing mid-row
               wait_drained();
               send_pixels(pixels_to_frame_end(), 0);
               case ($urandom_range(0, 2))
                  0: w = 2047;
                  1: w = MAX_WIDTH_DEFAULT;
                  default: w = $urandom_range(900, 1023);
               endcase
               set_geometry(CFG_W'(w), CFG_W'($urandom_range(1, 3)));
               send_pixels($urandom_range(30, 60), 10);
               set_geometry(CFG_W'($urandom_range(1, 4)), cfg_height);
               send_pixels($urandom_range(2, 8), 0);
            end
            8: begin
               // very tall frame, cut short by lowering the height mid-frame
               wait_drained();
               send_pixels(pixels_to_frame_end(), 0);
               h = ($urandom_range(0, 1) == 0) ? 2047 : MAX_HEIGHT;
               set_geometry(CFG_W'($urandom_range(1, 2)), CFG_W'(h));
               send_pixels($urandom_range(30, 50), 10);
               set_geometry(cfg_width, CFG_W'($urandom_range(1, 3)));
               send_pixels($urandom_range(2, 8), 0);
            end
            9: begin
               // sink holds off while the source keeps offering pixels
               holds_requested++;
               send_pixels($urandom_range(40, 60), 5);
            end
            10: begin
               for (int i = $urandom_range(5, 12); i > 0; i--)
                  queue_palette(IDX_W'($urandom), RGB_W'($urandom));
               send_pixels($urandom_range(1, 4), 30);
            end
            11: begin
               wait_drained();
               send_pixels($urandom_range(5, 20), 10);
            end
            default: begin
               w = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
               h = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
               set_geometry(CFG_W'(w), CFG_W'(h));
               n = $urandom_range(1, 2) * dimension_of(cfg_width, MAX_WIDTH_DEFAULT)
                   * dimension_of(cfg_height, MAX_HEIGHT);
               // sometimes stop mid-frame so the next geometry lands inside a frame
               if ($urandom_range(0, 3) == 0)
                  n = $urandom_range(1, n);
               send_pixels(n, 12);
            end
         endcase
      end

      wait_drained();
      repeat (16) @(posedge clock);
      $display("Covered %0d source items (%0d pixels, %0d palette writes) over %0d geometries",
               items_queued, pixels_queued, palette_queued, geometry_count);
      $display("Checked %0d output pixels; %0d pixels produced the full 3x3 window",
               pixels_checked, nine_runs);
      if (mismatches == 0 && expected_pixels.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
